### hdl/mbdrh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbdrh_pkg
// Shared types and constants for the multi-button debouncer with reset hold.
// ----------------------------------------------------------------------------
package mbdrh_pkg;

    localparam int BTN_COUNT   = 4;
    localparam int BTN_IDX_W   = 2;
    localparam int CNT_W       = 8;
    localparam int HOLD_THR_W  = 16;
    localparam int HOLD_W      = HOLD_THR_W + 1;
    localparam int RES_MAX     = BTN_COUNT + 2;
    localparam int RES_IDX_W   = $clog2(RES_MAX);
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    localparam logic [ADDR_W-1:0] ADDR_DEBOUNCE  = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] ADDR_HOLD      = ADDR_W'(4);
    localparam logic [ADDR_W-1:0] ADDR_COMBO     = ADDR_W'(8);
    localparam logic [ADDR_W-1:0] ADDR_RECOVERY  = ADDR_W'(12);
    localparam logic [ADDR_W-1:0] ADDR_ENABLE    = ADDR_W'(16);

    localparam logic [CNT_W-1:0]      RST_DEBOUNCE = CNT_W'(20);
    localparam logic [HOLD_THR_W-1:0] RST_HOLD     = HOLD_THR_W'(2500);
    localparam logic [BTN_COUNT-1:0]  RST_COMBO    = BTN_COUNT'(5);
    localparam logic [BTN_COUNT-1:0]  RST_RECOVERY = BTN_COUNT'(2);
    localparam logic                  RST_ENABLE   = 1'b1;

    typedef enum logic [1:0] {
        KIND_DOWN  = 2'd0,
        KIND_UP    = 2'd1,
        KIND_RESET = 2'd2,
        KIND_DONE  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [CNT_W-1:0]      debounce;
        logic [HOLD_THR_W-1:0] hold;
        logic [BTN_COUNT-1:0]  combo;
        logic [BTN_COUNT-1:0]  recovery;
        logic                  enable;
    } t_cfg;

    typedef struct packed {
        logic differ;
        logic flip;
        logic deb_next;
    } t_lane_st;

    typedef struct packed {
        t_kind                kind;
        logic [BTN_IDX_W-1:0] button;
        logic                 force_recovery;
        logic                 may_idle;
        logic                 last;
    } t_result;

    typedef t_result [RES_MAX-1:0] t_list;

endpackage
`default_nettype wire

### hdl/mbdrh_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbdrh_lane
// One button: change counter and debounced state bit.
// ----------------------------------------------------------------------------
module mbdrh_lane import mbdrh_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_raw,
    input  wire logic [CNT_W-1:0] i_debounce,
    output t_lane_st              o_st
);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_deb, n_deb;
    logic [CNT_W-1:0] cnt_inc;

    always_comb begin
        cnt_inc       = r_cnt + CNT_W'(1);
        o_st.differ   = (i_raw != r_deb);
        o_st.flip     = o_st.differ && (cnt_inc == i_debounce);
        n_deb         = o_st.flip ? i_raw : r_deb;
        o_st.deb_next = n_deb;
        if (!o_st.differ || o_st.flip) begin
            n_cnt = '0;
        end else begin
            n_cnt = cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_deb <= 1'b0;
        end else if (i_en) begin
            r_cnt <= n_cnt;
            r_deb <= n_deb;
        end
    end

endmodule
`default_nettype wire

### hdl/mbdrh_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbdrh_merge
// Combines lane events, runs the reset hold timer and builds the result list.
// ----------------------------------------------------------------------------
module mbdrh_merge import mbdrh_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire t_cfg                      i_cfg,
    input  wire t_lane_st [BTN_COUNT-1:0]  i_lane,
    output t_list                          o_list
);

    logic [HOLD_W-1:0]    r_hold, n_hold;
    logic [HOLD_W-1:0]    hold_inc;
    logic [HOLD_W-1:0]    thr;
    logic [BTN_COUNT-1:0] deb;
    logic                 any_differ;
    logic                 held;
    logic                 fire;
    logic [RES_IDX_W-1:0] n;

    always_comb begin
        o_list     = '0;
        n          = '0;
        any_differ = 1'b0;
        for (int i = 0; i < BTN_COUNT; i++) begin
            deb[i] = i_lane[i].deb_next;
            any_differ = any_differ | i_lane[i].differ;
            if (i_lane[i].flip) begin
                o_list[n].kind   = i_lane[i].deb_next ? KIND_DOWN : KIND_UP;
                o_list[n].button = BTN_IDX_W'(i);
                n = n + RES_IDX_W'(1);
            end
        end

        thr      = {1'b0, i_cfg.hold};
        hold_inc = r_hold + HOLD_W'(1);
        held     = i_cfg.enable && ((deb & i_cfg.combo) == i_cfg.combo);
        fire     = 1'b0;
        n_hold   = r_hold;
        if (!held) begin
            n_hold = '0;
        end else if (r_hold <= thr) begin
            n_hold = hold_inc;
            fire   = (hold_inc > thr);
        end

        if (fire) begin
            o_list[n].kind           = KIND_RESET;
            o_list[n].force_recovery = ((deb & i_cfg.recovery) != '0);
            n = n + RES_IDX_W'(1);
        end

        o_list[n].kind     = KIND_DONE;
        o_list[n].may_idle = !any_differ && !held;
        o_list[n].last     = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= '0;
        end else if (i_en) begin
            r_hold <= n_hold;
        end
    end

endmodule
`default_nettype wire

### hdl/mbdrh_obuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbdrh_obuf
// Holds one tick's result list and sends it out one transfer per cycle while not stalled.
// ----------------------------------------------------------------------------
module mbdrh_obuf import mbdrh_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_load,
    input  wire t_list i_list,
    input  wire logic  i_stall,
    output logic       o_free,
    output logic       o_valid,
    output t_result    o_res
);

    t_list                r_list;
    logic [RES_IDX_W-1:0] r_idx;
    logic                 r_valid;
    logic                 xfer;

    always_comb begin
        o_res   = r_list[r_idx];
        o_valid = r_valid;
        xfer    = r_valid && !i_stall;
        o_free  = !r_valid || (xfer && o_res.last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (xfer) begin
            if (o_res.last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + RES_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_list <= i_list;
        end
    end

endmodule
`default_nettype wire

### hdl/multi_button_debounce_reset_hold_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_button_debounce_reset_hold_top
// Four-button debouncer with reset-combination hold detection.
// ----------------------------------------------------------------------------
// Each input transfer is one sample tick. The tick is captured in an input
// register; when the output buffer is free, all button lanes update in
// parallel and the tick's results (button events in button order, an optional
// reset request, then a tick-done result flagged last) are loaded into an
// output buffer that sends one result per cycle unless the output is stalled.
// A tick has 1 to 6 results; the next tick is taken into the input register
// while the previous results drain, and its first result follows the previous
// tick's last one without a gap.
// ----------------------------------------------------------------------------
module multi_button_debounce_reset_hold_top import mbdrh_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_W-1:0]    paddr,
    input  wire logic [DATA_W-1:0]    pwdata,
    output logic      [DATA_W-1:0]    prdata,
    output logic                      pready,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [BTN_COUNT-1:0] i_pressed_bits,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic      [1:0]           o_kind,
    output logic      [BTN_IDX_W-1:0] o_button,
    output logic                      o_force_recovery,
    output logic                      o_may_idle,
    output logic                      o_last
);

    t_cfg                      r_cfg;
    logic                      r_in_valid;
    logic [BTN_COUNT-1:0]      r_in_bits;
    logic                      cfg_wr;
    logic                      buf_free;
    logic                      move;
    logic                      in_xfer;
    t_lane_st [BTN_COUNT-1:0]  lane;
    t_list                     list;
    t_result                   res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce <= RST_DEBOUNCE;
            r_cfg.hold     <= RST_HOLD;
            r_cfg.combo    <= RST_COMBO;
            r_cfg.recovery <= RST_RECOVERY;
            r_cfg.enable   <= RST_ENABLE;
        end else if (cfg_wr) begin
            unique case ({paddr[ADDR_W-1:2], 2'b00})
                ADDR_DEBOUNCE: r_cfg.debounce <= pwdata[CNT_W-1:0];
                ADDR_HOLD:     r_cfg.hold     <= pwdata[HOLD_THR_W-1:0];
                ADDR_COMBO:    r_cfg.combo    <= pwdata[BTN_COUNT-1:0];
                ADDR_RECOVERY: r_cfg.recovery <= pwdata[BTN_COUNT-1:0];
                ADDR_ENABLE:   r_cfg.enable   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case ({paddr[ADDR_W-1:2], 2'b00})
            ADDR_DEBOUNCE: prdata = DATA_W'(r_cfg.debounce);
            ADDR_HOLD:     prdata = DATA_W'(r_cfg.hold);
            ADDR_COMBO:    prdata = DATA_W'(r_cfg.combo);
            ADDR_RECOVERY: prdata = DATA_W'(r_cfg.recovery);
            ADDR_ENABLE:   prdata = DATA_W'(r_cfg.enable);
            default:       prdata = '0;
        endcase
    end

    assign move       = r_in_valid && buf_free;
    assign o_in_stall = r_in_valid && !buf_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_bits <= i_pressed_bits;
        end
    end

    for (genvar g = 0; g < BTN_COUNT; g++) begin : g_lane
        mbdrh_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (move),
            .i_raw      (r_in_bits[g]),
            .i_debounce (r_cfg.debounce),
            .o_st       (lane[g])
        );
    end

    mbdrh_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (move),
        .i_cfg   (r_cfg),
        .i_lane  (lane),
        .o_list  (list)
    );

    mbdrh_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (move),
        .i_list  (list),
        .i_stall (i_out_stall),
        .o_free  (buf_free),
        .o_valid (o_out_valid),
        .o_res   (res)
    );

    assign o_kind           = res.kind;
    assign o_button         = res.button;
    assign o_force_recovery = res.force_recovery;
    assign o_may_idle       = res.may_idle;
    assign o_last           = res.last;

endmodule
`default_nettype wire

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the four-button debouncer with reset-hold detection.
// A short directed table (debounce flips, reset requests, saturation, empty
// masks, disabled detection, unused addresses) is followed by random sample
// runs under several register settings. Every tick is scored against an
// in-bench model of the debouncer. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mbdrh_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int MAX_WAIT    = 17;

    localparam logic [ADDR_W-1:0] ADDR_SPARE_LO = ADDR_W'(20);
    localparam logic [ADDR_W-1:0] ADDR_SPARE_HI = ADDR_W'(28);

    typedef enum {STEP_TICK, STEP_WRITE} t_step;

    typedef struct {
        t_step                op;
        logic [ADDR_W-1:0]    addr;
        logic [DATA_W-1:0]    data;
        logic [BTN_COUNT-1:0] bits;
        bit                   typed;
        t_result              want;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [BTN_COUNT-1:0] i_pressed_bits = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [1:0]           o_kind;
    logic [BTN_IDX_W-1:0] o_button;
    logic                 o_force_recovery;
    logic                 o_may_idle;
    logic                 o_last;

    multi_button_debounce_reset_hold_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_pressed_bits   (i_pressed_bits),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kind           (o_kind),
        .o_button         (o_button),
        .o_force_recovery (o_force_recovery),
        .o_may_idle       (o_may_idle),
        .o_last           (o_last)
    );

    always #5 i_clk = ~i_clk;

    // debouncer model state
    t_cfg                 shadow_regs = '{RST_DEBOUNCE, RST_HOLD, RST_COMBO, RST_RECOVERY,
                                          RST_ENABLE};
    logic [CNT_W-1:0]     lane_count [BTN_COUNT] = '{default: '0};
    logic [BTN_COUNT-1:0] stable_bits = '0;
    logic [HOLD_W-1:0]    hold_count = '0;

    t_result pending_results [$];
    t_result oldest_result;
    t_row    directed_rows [$];
    int      mismatch_count = 0;
    int      quiet_cycles = 0;
    int      rx_wait_left = 0;
    bit      rx_idle_on = 1'b1;
    bit      rx_long_hold = 1'b0;
    bit      tx_idle_on = 1'b1;
    bit      tx_offering = 1'b0;

    function automatic int debounce_tick(input logic [BTN_COUNT-1:0] raw, output t_list res);
        int   n;
        logic quiet;
        n = 0;
        quiet = 1'b1;
        res = '0;
        for (int b = 0; b < BTN_COUNT; b++) begin
            if (raw[b] == stable_bits[b]) begin
                lane_count[b] = '0;
            end else begin
                quiet = 1'b0;
                lane_count[b] = lane_count[b] + CNT_W'(1);
                if (lane_count[b] == shadow_regs.debounce) begin
                    lane_count[b] = '0;
                    stable_bits[b] = raw[b];
                    res[n] = t_result'{raw[b] ? KIND_DOWN : KIND_UP, BTN_IDX_W'(b),
                                       1'b0, 1'b0, 1'b0};
                    n++;
                end
            end
        end
        if (shadow_regs.enable && ((stable_bits & shadow_regs.combo) == shadow_regs.combo)) begin
            quiet = 1'b0;
            if (hold_count <= {1'b0, shadow_regs.hold}) begin
                hold_count = hold_count + HOLD_W'(1);
                if (hold_count > {1'b0, shadow_regs.hold}) begin
                    res[n] = t_result'{KIND_RESET, '0, |(stable_bits & shadow_regs.recovery),
                                       1'b0, 1'b0};
                    n++;
                end
            end
        end else begin
            hold_count = '0;
        end
        res[n] = t_result'{KIND_DONE, '0, 1'b0, quiet, 1'b1};
        n++;
        return n;
    endfunction

    function automatic bit store_reg(input logic [ADDR_W-1:0] addr,
                                     input logic [DATA_W-1:0] data);
        case (addr)
            ADDR_DEBOUNCE: shadow_regs.debounce = data[CNT_W-1:0];
            ADDR_HOLD:     shadow_regs.hold = data[HOLD_THR_W-1:0];
            ADDR_COMBO:    shadow_regs.combo = data[BTN_COUNT-1:0];
            ADDR_RECOVERY: shadow_regs.recovery = data[BTN_COUNT-1:0];
            ADDR_ENABLE:   shadow_regs.enable = data[0];
            default:       return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic logic [DATA_W-1:0] reg_value(input logic [ADDR_W-1:0] addr);
        case (addr)
            ADDR_DEBOUNCE: return DATA_W'(shadow_regs.debounce);
            ADDR_HOLD:     return DATA_W'(shadow_regs.hold);
            ADDR_COMBO:    return DATA_W'(shadow_regs.combo);
            ADDR_RECOVERY: return DATA_W'(shadow_regs.recovery);
            ADDR_ENABLE:   return DATA_W'(shadow_regs.enable);
            default:       return '0;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void add_tick(input logic [BTN_COUNT-1:0] bits);
        directed_rows.push_back('{STEP_TICK, '0, '0, bits, 1'b0, '0});
    endfunction

    function automatic void add_quiet_tick(input logic [BTN_COUNT-1:0] bits, input logic idle);
        directed_rows.push_back('{STEP_TICK, '0, '0, bits, 1'b1,
                                  t_result'{KIND_DONE, '0, 1'b0, idle, 1'b1}});
    endfunction

    function automatic void add_write(input logic [ADDR_W-1:0] addr,
                                      input logic [DATA_W-1:0] data);
        directed_rows.push_back('{STEP_WRITE, addr, data, '0, 1'b0, '0});
    endfunction

    task automatic release_input();
        if (tx_offering) begin
            i_in_valid <= 1'b0;
            tx_offering = 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drain();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_tick(input logic [BTN_COUNT-1:0] bits, input bit typed,
                             input t_result want);
        t_list predicted;
        int    count;
        int    gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            release_input();
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pressed_bits <= bits;
        tx_offering = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        count = debounce_tick(bits, predicted);
        if (typed) begin
            pending_results.push_back(want);
        end else begin
            for (int k = 0; k < count; k++) pending_results.push_back(predicted[k]);
        end
    endtask

    task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data, output logic [DATA_W-1:0] rd);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        logic [DATA_W-1:0] rd;
        release_input();
        wait_drain();
        apb_access(1'b1, addr, data, rd);
        if (store_reg(addr, data)) begin
            apb_access(1'b0, addr, '0, rd);
            check_field("register readback", reg_value(addr), rd);
        end
    endtask

    task automatic apply_setup(input int deb, input int hold, input int combo,
                               input int recov, input int en);
        cfg_write(ADDR_DEBOUNCE, DATA_W'(deb));
        cfg_write(ADDR_HOLD, DATA_W'(hold));
        cfg_write(ADDR_COMBO, DATA_W'(combo));
        cfg_write(ADDR_RECOVERY, DATA_W'(recov));
        cfg_write(ADDR_ENABLE, DATA_W'(en));
    endtask

    // runs of a steady pattern near the debounce length, with glitches
    task automatic random_burst(input int total);
        int                   left;
        int                   len;
        int                   span;
        logic [BTN_COUNT-1:0] pattern;
        logic [BTN_COUNT-1:0] bits;
        left = total;
        while (left > 0) begin
            span = (shadow_regs.debounce == 0) ? 8 : int'(shadow_regs.debounce);
            pattern = BTN_COUNT'($urandom_range(0, 15));
            len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(1, span + 12);
            if ($urandom_range(0, 3) == 0) tx_idle_on = !tx_idle_on;
            if ($urandom_range(0, 3) == 0) rx_idle_on = !rx_idle_on;
            for (int k = 0; k < len && left > 0; k++) begin
                bits = pattern;
                if ($urandom_range(0, 9) == 0) bits[$urandom_range(0, BTN_COUNT - 1)] ^= 1'b1;
                send_tick(bits, 1'b0, '0);
                left--;
            end
        end
    endtask

    // receiver: random stall after each transfer, long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_wait_left = 0;
        end else begin
            if (rx_long_hold) begin
                rx_long_hold = 1'b0;
                rx_wait_left = LONG_HOLD;
            end else if (o_out_valid && !i_out_stall) begin
                rx_wait_left = rx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            end
            if (rx_wait_left > 0) begin
                i_out_stall <= 1'b1;
                rx_wait_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // result scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: kind %0d button %0d", o_kind, o_button);
                mismatch_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                check_field("kind", oldest_result.kind, o_kind);
                check_field("button", oldest_result.button, o_button);
                check_field("force_recovery", oldest_result.force_recovery, o_force_recovery);
                check_field("may_idle", oldest_result.may_idle, o_may_idle);
                check_field("last", oldest_result.last, o_last);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || (psel && penable))
        begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        add_quiet_tick(4'h0, 1'b1);
        add_quiet_tick(4'hF, 1'b0);
        add_quiet_tick(4'h0, 1'b1);
        add_write(ADDR_DEBOUNCE, 1);
        add_write(ADDR_HOLD, 0);
        add_tick(4'b0101);
        add_tick(4'b0111);
        add_tick(4'b0000);
        add_tick(4'b1111);
        add_tick(4'b0000);
        add_write(ADDR_RECOVERY, 0);
        add_tick(4'b1111);
        add_tick(4'b0000);
        add_write(ADDR_COMBO, 0);
        add_tick(4'b0000);
        add_tick(4'b0000);
        add_write(ADDR_HOLD, 3);
        add_tick(4'b0000);
        add_tick(4'b0000);
        add_tick(4'b0000);
        add_write(ADDR_ENABLE, 0);
        add_quiet_tick(4'h0, 1'b1);
        add_write(ADDR_SPARE_LO, 32'hFFFF_FFFF);
        add_write(ADDR_SPARE_HI, 32'hFFFF_FFFF);
        add_quiet_tick(4'h0, 1'b1);
        add_tick(4'b1000);
        add_write(ADDR_DEBOUNCE, 255);
        add_tick(4'b0000);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].op == STEP_WRITE) begin
                cfg_write(directed_rows[r].addr, directed_rows[r].data);
            end else begin
                send_tick(directed_rows[r].bits, directed_rows[r].typed, directed_rows[r].want);
            end
        end

        apply_setup(3, 10, 5, 2, 1);
        random_burst(8);

        apply_setup(1, 0, 15, 15, 1);
        random_burst(6);

        // debounce length zero wraps to 256 samples
        apply_setup(0, 2, 15, 15, 1);
        for (int k = 0; k < 260; k++) send_tick(~stable_bits, 1'b0, '0);
        random_burst(2);

        apply_setup(255, 65535, 0, 0, 0);
        random_burst(3);

        apply_setup(2, 5, 3, 8, 1);
        random_burst(4);
        release_input();
        wait_drain();
        random_burst(4);

        // output hold-off while input keeps coming
        apply_setup(4, 20, 6, 1, 1);
        rx_long_hold = 1'b1;
        tx_idle_on = 1'b0;
        for (int k = 0; k < 8; k++) send_tick(BTN_COUNT'($urandom_range(0, 15)), 1'b0, '0);
        random_burst(6);

        release_input();
        wait_drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
